FILE: src/vgrc_pkg.sv
// Shared constants and types for the vertical gradient row color core.
// Field widths, register indexes and divider staging. No dependencies.
package vgrc_pkg;

  localparam int unsigned RowW     = 12;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned WeightW  = 8;
  localparam int unsigned CfgIdxW  = 2;

  // Weight bits resolved per divider stage
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = WeightW / DivBitsPerStage;

  localparam int unsigned MaxRowsDefault = 4096;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegTopColor    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBottomColor = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeight      = 2'd2;

  localparam logic [ColorW-1:0]  TopColorReset    = 24'h000000;
  localparam logic [ColorW-1:0]  BottomColorReset = 24'hFFFFFF;
  localparam logic [HeightW-1:0] HeightReset      = 13'd1;

  // Product of a 9-bit signed difference and a 9-bit signed weight
  localparam int unsigned ProdW = 2 * (ChanW + 1);

  typedef logic signed [ProdW-1:0] prod_t;

endpackage

FILE: src/vertical_gradient_row_color_core.sv
// Vertical gradient row color core: throughput one row per cycle while the output
// is not stalled; the pipeline is the clamp stage, four 2-bit restoring divider
// stages, a multiply stage and an output stage.
// A stalled output holds the pipeline; empty stages fill while downstream waits.
// rst_ni is asynchronous active low: clears all valid bits and loads the
// register reset values (top 0x000000, bottom 0xFFFFFF, height 1).
module vertical_gradient_row_color_core
  import vgrc_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MaxRowsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ColorW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [RowW-1:0]    row_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ColorW-1:0]  row_color_o,
  output logic               row_clamped_o
);

  localparam int unsigned NumStg = DivStages + 3;
  localparam int unsigned MulStg = DivStages + 1;
  localparam int unsigned OutStg = DivStages + 2;
  localparam logic [16:0] MaxRowsW = 17'(MAX_ROWS);

  // Configuration registers
  logic [ColorW-1:0]  top_q, bot_q;
  logic [HeightW-1:0] hgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= TopColorReset;
      bot_q <= BottomColorReset;
      hgt_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTopColor:    top_q <= cfg_wdata_i;
        RegBottomColor: bot_q <= cfg_wdata_i;
        RegHeight:      hgt_q <= cfg_wdata_i[HeightW-1:0];
        default:        ;
      endcase
    end
  end

  // Effective height; user must change config only with pipeline empty (unenforced)
  logic [HeightW-1:0] hgt_eff;
  always_comb begin
    hgt_eff = hgt_q;
    if (hgt_q == '0) begin
      hgt_eff = HeightW'(1);
    end else if ({4'b0, hgt_q} > MaxRowsW) begin
      hgt_eff = HeightW'(MAX_ROWS);
    end
  end

  // Stage control
  logic [NumStg-1:0] v_q;
  logic [NumStg-1:0] adv;

  always_comb begin
    adv[NumStg-1] = !v_q[NumStg-1] || !out_stall_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage payloads
  logic [HeightW-1:0] rem_q [DivStages+1];
  logic [WeightW-1:0] quo_q [DivStages+1];
  logic               clmp_q [NumStg];
  prod_t              prod_q [NumChan];
  logic [ColorW-1:0]  color_q;

  // Clamp the row to height-1
  logic [HeightW-1:0] row_c;
  logic               clmp_c;
  always_comb begin
    row_c  = {1'b0, row_index_i};
    clmp_c = 1'b0;
    if ({1'b0, row_index_i} >= hgt_eff) begin
      row_c  = hgt_eff - HeightW'(1);
      clmp_c = 1'b1;
    end
  end

  // Restoring division of row*256 by height, two quotient bits per stage
  logic [HeightW-1:0] rem_d [DivStages+1];
  logic [WeightW-1:0] quo_d [DivStages+1];
  always_comb begin
    logic [HeightW-1:0] r;
    logic [HeightW:0]   t;
    logic [WeightW-1:0] q;
    rem_d[0] = row_c;
    quo_d[0] = '0;
    for (int s = 1; s <= DivStages; s++) begin
      r = rem_q[s-1];
      q = quo_q[s-1];
      for (int b = 0; b < DivBitsPerStage; b++) begin
        t = {r, 1'b0};
        if (t >= {1'b0, hgt_eff}) begin
          r = HeightW'(t - {1'b0, hgt_eff});
          q = {q[WeightW-2:0], 1'b1};
        end else begin
          r = t[HeightW-1:0];
          q = {q[WeightW-2:0], 1'b0};
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end
  end

  // Channel products (bottom - top) * weight
  prod_t prod_d [NumChan];
  always_comb begin
    logic signed [ChanW:0] diff;
    logic signed [ChanW:0] wgt;
    wgt = $signed({1'b0, quo_q[DivStages]});
    for (int c = 0; c < NumChan; c++) begin
      diff = $signed({1'b0, bot_q[c*ChanW +: ChanW]})
           - $signed({1'b0, top_q[c*ChanW +: ChanW]});
      prod_d[c] = diff * wgt;
    end
  end

  // Divide by 256 toward zero and add the top channel
  logic [ColorW-1:0] color_d;
  always_comb begin
    prod_t step;
    prod_t sum;
    for (int c = 0; c < NumChan; c++) begin
      if (prod_q[c] < 0) begin
        step = (prod_q[c] + prod_t'(255)) >>> ChanW;
      end else begin
        step = prod_q[c] >>> ChanW;
      end
      sum = step + $signed({{(ProdW-ChanW){1'b0}}, top_q[c*ChanW +: ChanW]});
      color_d[c*ChanW +: ChanW] = sum[ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rem_q[0]  <= rem_d[0];
      quo_q[0]  <= quo_d[0];
      clmp_q[0] <= clmp_c;
    end
    for (int s = 1; s <= DivStages; s++) begin
      if (adv[s]) begin
        rem_q[s]  <= rem_d[s];
        quo_q[s]  <= quo_d[s];
        clmp_q[s] <= clmp_q[s-1];
      end
    end
    if (adv[MulStg]) begin
      for (int c = 0; c < NumChan; c++) prod_q[c] <= prod_d[c];
      clmp_q[MulStg] <= clmp_q[MulStg-1];
    end
    if (adv[OutStg]) begin
      color_q        <= color_d;
      clmp_q[OutStg] <= clmp_q[OutStg-1];
    end
  end

  assign out_valid_o   = v_q[OutStg];
  assign row_color_o   = color_q;
  assign row_clamped_o = clmp_q[OutStg];

`ifndef NO_ASSERTIONS
  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A full pipe behind a stalled result must stall the input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && out_stall_i) |-> in_stall_o)
    else $error("full pipeline accepted an input");

  // Partial remainder stays below the divisor in the first and last divider stages
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] |-> (rem_q[1] < hgt_eff))
    and (v_q[DivStages] |-> (rem_q[DivStages] < hgt_eff)))
    else $error("divider remainder out of range");
`endif

endmodule
